// ===== design/gfm_pkg.sv =====
// shared widths and the field polynomial for the gf(2^128) multiplier
// no dependencies; imported by gfm_clmul, gf128_full_multiply_core and tb_top
package gfm_pkg;

   localparam int GFM_WORD_W = 64;                     // one half of an element
   localparam int GFM_ELEM_W = 2 * GFM_WORD_W;         // field element width
   localparam int GFM_LIMB_W = 32;                     // carry-less multiplier slice
   localparam int GFM_LIMBS  = GFM_ELEM_W / GFM_LIMB_W;
   localparam int GFM_PP_W   = 2 * GFM_LIMB_W - 1;     // slice product width

   // low terms of x^128 + x^7 + x^2 + x + 1
   localparam int              GFM_POLY_DEG = 7;
   localparam logic [GFM_POLY_DEG:0] GFM_POLY_LOW = 8'h87;

   typedef logic [GFM_PP_W-1:0] pp_type;

endpackage

// ===== design/gf128_full_multiply_core.sv =====
// Multiplies two GF(2^128) elements (bit k of the big-endian 128-bit value is the
// coefficient of x^k) and reduces modulo x^128 + x^7 + x^2 + x + 1. The pipeline
// takes one transaction per cycle while no stall on rsp_ready holds it, and passes
// each through registered stages: 32x32 carry-less slice products, their sum into
// the 255-bit product, a first fold of the upper half, then a final fold of the
// few bits left over. Each stage holds its own valid bit, so a stall on rsp_ready
// backs up only as far as needed and req_ready stays high while any stage is empty.
// The block keeps no state between transactions; depends on gfm_pkg and gfm_clmul.
module gf128_full_multiply_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gfm_pkg::GFM_WORD_W-1:0] req_a_hi,
   input  logic [gfm_pkg::GFM_WORD_W-1:0] req_a_lo,
   input  logic [gfm_pkg::GFM_WORD_W-1:0] req_b_hi,
   input  logic [gfm_pkg::GFM_WORD_W-1:0] req_b_lo,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gfm_pkg::GFM_WORD_W-1:0] rsp_prod_hi,
   output logic [gfm_pkg::GFM_WORD_W-1:0] rsp_prod_lo
);
   import gfm_pkg::*;

   localparam int NUM_PP  = GFM_LIMBS * GFM_LIMBS;
   localparam int FULL_W  = 2 * GFM_ELEM_W - 1;
   localparam int HIGH_W  = FULL_W - GFM_ELEM_W;
   localparam int FOLD_W  = HIGH_W + GFM_POLY_DEG;
   localparam int CARRY_W = FOLD_W - GFM_ELEM_W;
   localparam int TAIL_W  = CARRY_W + GFM_POLY_DEG;

   logic [GFM_ELEM_W-1:0] a_op;
   logic [GFM_ELEM_W-1:0] b_op;

   // stage control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in;
   logic s1_free, s2_free, s3_free, s4_free;

   // stage payload
   pp_type                pp_in [NUM_PP];
   pp_type                pp_ff [NUM_PP];
   logic [FULL_W-1:0]     prod_in, prod_ff;
   logic [GFM_ELEM_W-1:0] lo_in, lo_ff;
   logic [CARRY_W-1:0]    carry_in, carry_ff;
   logic [GFM_ELEM_W-1:0] res_in, res_ff;

   assign a_op = {req_a_hi, req_a_lo};
   assign b_op = {req_b_hi, req_b_lo};

   // a stage can load when it is empty or its content moves on this cycle
   assign s4_free   = !s4_valid_ff || rsp_ready;
   assign s3_free   = !s3_valid_ff || s4_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;

   assign s1_valid_in = s1_free ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_free ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = s4_free ? s3_valid_ff : s4_valid_ff;

   // stage 1: slice products
   for (genvar gi = 0; gi < GFM_LIMBS; gi++) begin : g_row
      for (genvar gj = 0; gj < GFM_LIMBS; gj++) begin : g_col
         gfm_clmul u_clmul (
            .a (a_op[gi*GFM_LIMB_W +: GFM_LIMB_W]),
            .b (b_op[gj*GFM_LIMB_W +: GFM_LIMB_W]),
            .p (pp_in[gi*GFM_LIMBS + gj])
         );
      end
   end

   // stage 2: sum of slice products at their offsets
   always_comb begin
      prod_in = '0;
      for (int i = 0; i < GFM_LIMBS; i++) begin
         for (int j = 0; j < GFM_LIMBS; j++) begin
            prod_in = prod_in ^ (FULL_W'(pp_ff[i*GFM_LIMBS + j]) << (GFM_LIMB_W * (i + j)));
         end
      end
   end

   // stage 3: fold x^128 and up back down with x^128 = x^7 + x^2 + x + 1
   always_comb begin
      logic [FOLD_W-1:0] fold;
      fold = '0;
      for (int k = 0; k <= GFM_POLY_DEG; k++) begin
         if (GFM_POLY_LOW[k]) begin
            fold = fold ^ (FOLD_W'(prod_ff[FULL_W-1:GFM_ELEM_W]) << k);
         end
      end
      lo_in    = prod_ff[GFM_ELEM_W-1:0] ^ fold[GFM_ELEM_W-1:0];
      carry_in = fold[FOLD_W-1:GFM_ELEM_W];
   end

   // stage 4: the few bits that spilled past x^127 fold once more and stay low
   always_comb begin
      logic [TAIL_W-1:0] tail;
      tail = '0;
      for (int k = 0; k <= GFM_POLY_DEG; k++) begin
         if (GFM_POLY_LOW[k]) begin
            tail = tail ^ (TAIL_W'(carry_ff) << k);
         end
      end
      res_in = lo_ff ^ GFM_ELEM_W'(tail);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         pp_ff <= pp_in;
      end
      if (s2_free) begin
         prod_ff <= prod_in;
      end
      if (s3_free) begin
         lo_ff    <= lo_in;
         carry_ff <= carry_in;
      end
      if (s4_free) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid   = s4_valid_ff;
   assign rsp_prod_hi = res_ff[GFM_ELEM_W-1:GFM_WORD_W];
   assign rsp_prod_lo = res_ff[GFM_WORD_W-1:0];

endmodule

// ===== design/gfm_clmul.sv =====
// carry-less (gf(2)[x]) product of two limb-wide polynomials, combinational
// depends on gfm_pkg for the limb width and product type
module gfm_clmul (
   input  logic [gfm_pkg::GFM_LIMB_W-1:0] a,
   input  logic [gfm_pkg::GFM_LIMB_W-1:0] b,
   output gfm_pkg::pp_type                p
);
   import gfm_pkg::*;

   // each product bit is the parity of one anti-diagonal of the and array
   always_comb begin
      logic [GFM_LIMB_W-1:0] col;
      for (int k = 0; k < GFM_PP_W; k++) begin
         col = '0;
         for (int i = 0; i < GFM_LIMB_W; i++) begin
            if ((k - i) >= 0 && (k - i) < GFM_LIMB_W) begin
               col[i] = a[i] & b[k - i];
            end
         end
         p[k] = ^col;
      end
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for gf128_full_multiply_core: directed corners, random operands, back-pressure
// every product is predicted in gf(2^128) and compared in order; depends on gfm_pkg and gf128_full_multiply_core
module tb_top;
   import gfm_pkg::*;

   typedef logic [GFM_WORD_W-1:0] word_type;
   typedef logic [GFM_ELEM_W-1:0] elem_type;
   typedef struct packed {
      word_type hi;
      word_type lo;
   } product_type;

   localparam int STALL_LIMIT      = 2000;
   localparam int RANDOM_PER_PHASE = 420;
   localparam int DRAIN_CYCLES     = 10;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   word_type req_a_hi = '0;
   word_type req_a_lo = '0;
   word_type req_b_hi = '0;
   word_type req_b_lo = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   word_type rsp_prod_hi;
   word_type rsp_prod_lo;

   product_type expected_products[$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          rsp_hold_cycles = 0;
   int          quiet_cycles = 0;

   gf128_full_multiply_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_a_hi    (req_a_hi),
      .req_a_lo    (req_a_lo),
      .req_b_hi    (req_b_hi),
      .req_b_lo    (req_b_lo),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_prod_hi (rsp_prod_hi),
      .rsp_prod_lo (rsp_prod_lo)
   );

   always #6 clock = ~clock;

   // shift-and-add over b, top coefficient first, folding x^128 back as the low poly terms
   function automatic product_type gf128_product(input word_type a_hi, input word_type a_lo,
                                                 input word_type b_hi, input word_type b_lo);
      elem_type    a;
      elem_type    b;
      elem_type    acc;
      elem_type    poly;
      product_type p;
      a    = {a_hi, a_lo};
      b    = {b_hi, b_lo};
      acc  = '0;
      poly = '0;
      poly[GFM_POLY_DEG:0] = GFM_POLY_LOW;
      for (int k = GFM_ELEM_W - 1; k >= 0; k--) begin
         acc = {acc[GFM_ELEM_W-2:0], 1'b0} ^ (acc[GFM_ELEM_W-1] ? poly : '0);
         if (b[k]) begin
            acc ^= a;
         end
      end
      p.hi = acc[GFM_ELEM_W-1:GFM_WORD_W];
      p.lo = acc[GFM_WORD_W-1:0];
      return p;
   endfunction

   function automatic word_type rand_word();
      word_type w;
      w = '0;
      case ($urandom_range(9))
         0: w = '0;
         1: w = '1;
         2: w[$urandom_range(GFM_WORD_W - 1)] = 1'b1;
         3: w = word_type'($urandom_range(255));
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   task automatic report_mismatch(input string what, input word_type got, input word_type want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_operands(input word_type a_hi, input word_type a_lo,
                                input word_type b_hi, input word_type b_lo);
      bit accepted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_a_hi  <= a_hi;
      req_a_lo  <= a_lo;
      req_b_hi  <= b_hi;
      req_b_lo  <= b_lo;
      accepted = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         if (req_ready) begin
            expected_products.push_back(gf128_product(a_hi, a_lo, b_hi, b_lo));
            accepted = 1'b1;
         end
         @(negedge clock);
      end
   endtask

   task automatic wait_all_returned();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_products.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic test_directed_corners();
      word_type ones;
      word_type top;
      word_type one;
      word_type two;
      ones = '1;
      top  = word_type'(1) << (GFM_WORD_W - 1);
      one  = word_type'(1);
      two  = word_type'(2);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_operands('0, '0, '0, '0);
      send_operands('0, '0, ones, ones);
      send_operands(ones, ones, '0, '0);
      send_operands('0, one, '0, one);
      send_operands('0, one, ones, ones);
      send_operands(ones, ones, '0, one);
      // x^127 * x wraps straight into the reduction terms
      send_operands(top, '0, '0, two);
      send_operands(top, '0, top, '0);
      // x^64 * x^64 = x^128
      send_operands(one, '0, one, '0);
      send_operands('0, top, '0, two);
      send_operands(ones, ones, ones, ones);
      send_operands(ones, '0, '0, ones);
      send_operands('0, ones, ones, '0);
      send_operands({(GFM_WORD_W/4){4'hA}}, {(GFM_WORD_W/4){4'hA}},
                    {(GFM_WORD_W/4){4'h5}}, {(GFM_WORD_W/4){4'h5}});
      send_operands(top, one, top, one);
      send_operands('0, word_type'(GFM_POLY_LOW), word_type'(1) << 57, '0);
      send_operands(top, top, ones, '0);
      send_operands('0, ones, top, top);
      send_operands({$urandom, $urandom}, {$urandom, $urandom}, '0, '0);
      send_operands({$urandom, $urandom}, {$urandom, $urandom}, '0, one);
      wait_all_returned();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         send_operands(rand_word(), rand_word(), rand_word(), rand_word());
      end
      wait_all_returned();
   endtask

   // receiver holds off long enough for the pipeline to fill and stall the request side
   task automatic test_backpressure_fill();
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      rsp_hold_cycles = 250;
      for (int i = 0; i < 60; i++) begin
         send_operands({$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom});
      end
      wait_all_returned();
   endtask

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      product_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_products.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_prod_hi, '0);
         end else begin
            want = expected_products.pop_front();
            if (rsp_prod_hi !== want.hi) begin
               report_mismatch("prod_hi", rsp_prod_hi, want.hi);
            end
            if (rsp_prod_lo !== want.lo) begin
               report_mismatch("prod_lo", rsp_prod_lo, want.lo);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_corners();
      test_random_traffic(0, 0, RANDOM_PER_PHASE);
      test_random_traffic(74, 0, RANDOM_PER_PHASE);
      test_random_traffic(0, 74, RANDOM_PER_PHASE);
      test_backpressure_fill();
      test_random_traffic(12, 12, RANDOM_PER_PHASE);
      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
